>>> src/sdss_pkg.sv
// Shared types and constants for the SCAN disk seek scheduler.
// No dependencies; the top, front and back files use it by scoped names.
package sdss_pkg;

  // Reset value of the upper disk end register
  localparam int LAST_TRACK_RESET = 199;

  // Command classification passed from the front end to the back end
  typedef struct packed {
    logic run;       // 1 = run the schedule, 0 = load a request
    logic up_first;  // run only: move toward higher tracks first
  } cmd_t;

endpackage

>>> src/scan_disk_seek_scheduler_top.sv
// SCAN disk seek scheduler. A load word is inserted in sorted order; each stored request
// above it is shifted up one slot, one RAM read per shift. A run word walks the store in
// two passes (three when down first), giving one result word per match and per disk end
// step, at least one word; a stalled result port stalls the walk. Two-entry command queue
// decouples input from the back end. Reset (rst_n, sync, active low) empties queue and
// store and sets the upper disk end to 199.
module scan_disk_seek_scheduler_top #(
  parameter int QUEUE_DEPTH = 32,
  parameter int TRACK_BITS  = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration: upper disk end
  input  logic                                cfg_wr_en,
  input  logic [TRACK_BITS-1:0]               cfg_wdata,
  // Input words
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((TRACK_BITS+8)/8)*8-1:0]     in_tdata,   // position, up_first, zero pad
  input  logic                                in_tuser,   // op
  // Result words
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [((2*TRACK_BITS+8)/8)*8-1:0]   out_tdata,  // track, total_seek, zero pad
  output logic                                out_tlast,  // last
  output logic                                out_tuser   // overflowed
);

  localparam int TW  = TRACK_BITS;
  localparam int ODW = ((2*TRACK_BITS+8)/8)*8;

  logic [TW-1:0]   last_track_r;
  logic            cmd_valid;
  logic            cmd_ready;
  sdss_pkg::cmd_t  cmd;
  logic [TW-1:0]   cmd_pos;
  logic [TW-1:0]   res_track;
  logic [TW:0]     res_total;

  // Upper disk end register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_track_r <= TW'(sdss_pkg::LAST_TRACK_RESET);
    end else if (cfg_wr_en) begin
      last_track_r <= cfg_wdata;
    end
  end

  sdss_front #(
    .TRACK_BITS(TRACK_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .last_track  (last_track_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_op       (in_tuser),
    .in_position (in_tdata[TW-1:0]),
    .in_up_first (in_tdata[TW]),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .cmd_pos     (cmd_pos)
  );

  sdss_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TRACK_BITS (TRACK_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .last_track     (last_track_r),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .cmd            (cmd),
    .cmd_pos        (cmd_pos),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_track      (res_track),
    .out_total_seek (res_total),
    .out_last       (out_tlast),
    .out_overflowed (out_tuser)
  );

  assign out_tdata = ODW'({res_total, res_track});

endmodule

>>> src/sdss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sdss_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port; read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/sdss_front.sv
// Front end: accepts input words, classifies them and queues commands.
// Depends on sdss_pkg (cmd_t).
module sdss_front #(
  parameter int TRACK_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [TRACK_BITS-1:0] last_track,
  // Input word, already unpacked
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic [TRACK_BITS-1:0] in_position,
  input  logic                  in_up_first,
  // Command queue head toward the back end
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output sdss_pkg::cmd_t        cmd,
  output logic [TRACK_BITS-1:0] cmd_pos
);

  localparam int QDEPTH = 2;

  sdss_pkg::cmd_t        fq_cmd_r [QDEPTH];
  logic [TRACK_BITS-1:0] fq_pos_r [QDEPTH];
  logic                  wp_r, wp_nxt;
  logic                  rp_r, rp_nxt;
  logic [1:0]            fill_r, fill_nxt;
  logic                  push, pop;
  sdss_pkg::cmd_t        cls_cmd;
  logic [TRACK_BITS-1:0] cls_pos;

  // Classify: a run carries the head track saturated at the upper end
  always_comb begin
    cls_cmd.run      = in_op;
    cls_cmd.up_first = in_up_first;
    cls_pos          = in_position;
    if (in_op && (in_position > last_track)) begin
      cls_pos = last_track;
    end
  end

  assign in_ready  = (fill_r != 2'(QDEPTH));
  assign cmd_valid = (fill_r != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = fq_cmd_r[rp_r];
  assign cmd_pos   = fq_pos_r[rp_r];

  // Queue pointers and fill level
  always_comb begin
    wp_nxt   = push ? ~wp_r : wp_r;
    rp_nxt   = pop ? ~rp_r : rp_r;
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      fq_cmd_r[wp_r] <= cls_cmd;
      fq_pos_r[wp_r] <= cls_pos;
    end
  end

endmodule

>>> src/sdss_back.sv
// Back end: sorted insert of loads into the request RAM and SCAN walk for runs.
// Depends on sdss_pkg (cmd_t) and sdss_ram.
module sdss_back #(
  parameter int QUEUE_DEPTH = 32,
  parameter int TRACK_BITS  = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [TRACK_BITS-1:0] last_track,
  // Command from the front end
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  sdss_pkg::cmd_t        cmd,
  input  logic [TRACK_BITS-1:0] cmd_pos,
  // Result register
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TRACK_BITS-1:0] out_track,
  output logic [TRACK_BITS:0]   out_total_seek,
  output logic                  out_last,
  output logic                  out_overflowed
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = TRACK_BITS;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_LD_RD   = 7'b0000010,
    ST_LD_CHK  = 7'b0000100,
    ST_RUN_RD  = 7'b0001000,
    ST_RUN_CHK = 7'b0010000,
    ST_RUN_END = 7'b0100000,
    ST_RUN_FIN = 7'b1000000
  } state_t;

  // Scan passes over the sorted store
  typedef enum logic [4:0] {
    PH_UP_GE = 5'b00001,  // ascending, at or above head
    PH_UP_LT = 5'b00010,  // descending, below head
    PH_DN_EQ = 5'b00100,  // ascending, on head
    PH_DN_LT = 5'b01000,  // descending, below head
    PH_DN_GT = 5'b10000   // ascending, above head
  } phase_t;

  state_t        st_r, st_nxt;
  phase_t        ph_r, ph_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          drop_r, drop_nxt;
  logic [TW-1:0] pos_r, pos_nxt;
  logic          up_r, up_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [TW-1:0] pend_trk_r, pend_trk_nxt;
  logic [TW:0]   tot_r, tot_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [TW-1:0] out_trk_r, out_trk_nxt;
  logic [TW:0]   out_tot_r, out_tot_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [TW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [TW-1:0] ram_rdata;

  logic [CW-1:0] idx_m1;
  logic [TW-1:0] sat_d;
  logic          asc;
  logic          scan_done;
  logic          match;
  logic          out_free;
  logic          emit_ok;
  logic [TW-1:0] cur_trk;
  logic [TW-1:0] cand;
  logic [TW-1:0] step_dist;
  logic [TW:0]   new_tot;
  logic [TW-1:0] end_trk;

  sdss_ram #(
    .WIDTH(TW),
    .DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Datapath helpers
  assign idx_m1    = idx_r - CW'(1);
  assign sat_d     = (ram_rdata > last_track) ? last_track : ram_rdata;
  assign asc       = (ph_r == PH_UP_GE) || (ph_r == PH_DN_EQ) || (ph_r == PH_DN_GT);
  assign scan_done = asc ? (idx_r == cnt_r) : (idx_r == '0);
  assign out_free  = !out_valid_r || out_ready;
  assign emit_ok   = !pend_v_r || out_free;
  assign cur_trk   = pend_v_r ? pend_trk_r : pos_r;
  assign end_trk   = up_r ? last_track : '0;
  assign cand      = (st_r == ST_RUN_END) ? end_trk : sat_d;
  assign step_dist = (cand >= cur_trk) ? (cand - cur_trk) : (cur_trk - cand);
  assign new_tot   = (pend_v_r ? tot_r : '0) + (TW+1)'(step_dist);

  always_comb begin
    case (ph_r)
      PH_UP_GE: match = (sat_d >= pos_r);
      PH_UP_LT: match = (sat_d < pos_r);
      PH_DN_EQ: match = (sat_d == pos_r);
      PH_DN_LT: match = (sat_d < pos_r);
      PH_DN_GT: match = (sat_d > pos_r);
      default:  match = 1'b0;
    endcase
  end

  assign cmd_ready = (st_r == ST_IDLE);

  // Sequencer
  always_comb begin
    st_nxt       = st_r;
    ph_nxt       = ph_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    drop_nxt     = drop_r;
    pos_nxt      = pos_r;
    up_nxt       = up_r;
    pend_v_nxt   = pend_v_r;
    pend_trk_nxt = pend_trk_r;
    tot_nxt      = tot_r;
    ram_we       = 1'b0;
    ram_waddr    = idx_r[AW-1:0];
    ram_wdata    = pos_r;
    ram_re       = 1'b0;
    ram_raddr    = asc ? idx_r[AW-1:0] : idx_m1[AW-1:0];

    // result register drains, and takes a new word when pushed below
    out_valid_nxt = out_valid_r && !out_ready;
    out_trk_nxt   = out_trk_r;
    out_tot_nxt   = out_tot_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;

    case (st_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          pos_nxt = cmd_pos;
          up_nxt  = cmd.up_first;
          if (cmd.run) begin
            idx_nxt    = '0;
            pend_v_nxt = 1'b0;
            ph_nxt     = cmd.up_first ? PH_UP_GE : PH_DN_EQ;
            st_nxt     = ST_RUN_RD;
          end else if (cnt_r == CW'(QUEUE_DEPTH)) begin
            drop_nxt = 1'b1;
          end else begin
            idx_nxt = cnt_r;
            st_nxt  = ST_LD_RD;
          end
        end
      end

      // sorted insert: shift larger entries up one slot
      ST_LD_RD: begin
        if (idx_r == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          cnt_nxt   = cnt_r + CW'(1);
          st_nxt    = ST_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_m1[AW-1:0];
          st_nxt    = ST_LD_CHK;
        end
      end

      ST_LD_CHK: begin
        ram_we = 1'b1;
        if (ram_rdata > pos_r) begin
          ram_wdata = ram_rdata;
          idx_nxt   = idx_m1;
          st_nxt    = ST_LD_RD;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
          st_nxt  = ST_IDLE;
        end
      end

      // run: issue a read or move on to the next pass
      ST_RUN_RD: begin
        if (scan_done) begin
          case (ph_r)
            PH_UP_GE: st_nxt = ST_RUN_END;
            PH_DN_EQ: begin
              ph_nxt  = PH_DN_LT;
              idx_nxt = cnt_r;
            end
            PH_DN_LT: st_nxt = ST_RUN_END;
            default:  st_nxt = ST_RUN_FIN;
          endcase
        end else begin
          ram_re = 1'b1;
          st_nxt = ST_RUN_CHK;
        end
      end

      ST_RUN_CHK: begin
        if (!match || emit_ok) begin
          idx_nxt = asc ? (idx_r + CW'(1)) : idx_m1;
          st_nxt  = ST_RUN_RD;
        end
        if (match && emit_ok) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_trk_nxt   = pend_trk_r;
            out_tot_nxt   = tot_r;
            out_last_nxt  = 1'b0;
            out_ovf_nxt   = drop_r;
          end
          pend_v_nxt   = 1'b1;
          pend_trk_nxt = sat_d;
          tot_nxt      = new_tot;
        end
      end

      // disk end step, skipped when the head already stands there
      ST_RUN_END: begin
        if (cur_trk == end_trk || emit_ok) begin
          ph_nxt  = up_r ? PH_UP_LT : PH_DN_GT;
          idx_nxt = up_r ? cnt_r : '0;
          st_nxt  = ST_RUN_RD;
        end
        if (cur_trk != end_trk && emit_ok) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_trk_nxt   = pend_trk_r;
            out_tot_nxt   = tot_r;
            out_last_nxt  = 1'b0;
            out_ovf_nxt   = drop_r;
          end
          pend_v_nxt   = 1'b1;
          pend_trk_nxt = end_trk;
          tot_nxt      = new_tot;
        end
      end

      // final word of the run; empty the store and clear the overflow flag afterwards
      ST_RUN_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_trk_nxt   = pend_v_r ? pend_trk_r : pos_r;
          out_tot_nxt   = pend_v_r ? tot_r : '0;
          out_last_nxt  = 1'b1;
          out_ovf_nxt   = drop_r;
          pend_v_nxt    = 1'b0;
          cnt_nxt       = '0;
          drop_nxt      = 1'b0;
          st_nxt        = ST_IDLE;
        end
      end

      default: st_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      ph_r        <= PH_UP_GE;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      ph_r        <= ph_nxt;
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    up_r       <= up_nxt;
    pend_trk_r <= pend_trk_nxt;
    tot_r      <= tot_nxt;
    out_trk_r  <= out_trk_nxt;
    out_tot_r  <= out_tot_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_track      = out_trk_r;
  assign out_total_seek = out_tot_r;
  assign out_last       = out_last_r;
  assign out_overflowed = out_ovf_r;

endmodule
